// ===== src/wrr5q_pkg.sv =====
// shared types and constants of the weighted round robin queue scheduler
`default_nettype none
package wrr5q_pkg;

   localparam int unsigned NUM_CLASSES = 5;

   localparam logic [2:0] MAX_CLASS   = 3'd5;
   localparam logic [2:0] LAST_QUEUE  = 3'd4;
   localparam logic [2:0] PROBE_LIMIT = 3'd5;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_SERVE   = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NO_CLIENT = 2'd2;

   localparam logic [2:0] REG_QUOTA_CLASS1   = 3'd0;
   localparam logic [2:0] REG_QUOTA_CLASS2   = 3'd1;
   localparam logic [2:0] REG_QUOTA_CLASS3   = 3'd2;
   localparam logic [2:0] REG_QUOTA_CLASS4   = 3'd3;
   localparam logic [2:0] REG_QUOTA_CLASS5   = 3'd4;
   localparam logic [2:0] REG_TIME_PER_OP    = 3'd5;

   typedef struct packed {
      logic [30:0] account;
      logic [15:0] operations;
   } entry_type;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_EXEC  = 6'b000010,
      S_PROBE = 6'b000100,
      S_FETCH = 6'b001000,
      S_MUL   = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

endpackage
`default_nettype wire

// ===== src/wrr5q_store.sv =====
// entry storage for all class queues: one write port, one registered read port
`default_nettype none
module wrr5q_store #(
   parameter int unsigned ENTRIES = 80,
   localparam int unsigned ADDR_W = $clog2(ENTRIES)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_W-1:0]    wr_addr,
   input  wire wrr5q_pkg::entry_type wr_entry,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_W-1:0]    rd_addr,
   output wrr5q_pkg::entry_type      rd_entry
);
   import wrr5q_pkg::*;

   entry_type mem [0:ENTRIES-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== src/weighted_round_robin_five_queues.sv =====
// enqueue: the EXEC state writes the entry, then DONE passes the result to the output register
// serve: the probe sequencer steps one queue per cycle (up to five steps plus a final check),
// then the FETCH state reads the entry and the MUL state forms the 16x16 service time product
// throughput: one item at a time; the next beat is taken once the result is in the
// output register, which may still wait on rsp_stall
// reset: synchronous; queues empty, pointer on class 1, quotas and time per operation 1
`default_nettype none
module weighted_round_robin_five_queues #(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_command,
   input  wire logic [2:0]  req_class_number,
   input  wire logic [30:0] req_account_number,
   input  wire logic [15:0] req_operation_count,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [30:0]      rsp_served_account,
   output logic [15:0]      rsp_served_operations,
   output logic [31:0]      rsp_service_time,
   output logic [2:0]       rsp_served_class,
   output logic [6:0]       rsp_total_waiting,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);
   import wrr5q_pkg::*;

   localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned HEAD_W  = $clog2(QUEUE_DEPTH);
   localparam int unsigned ENTRIES = NUM_CLASSES * QUEUE_DEPTH;
   localparam int unsigned ADDR_W  = $clog2(ENTRIES);
   localparam int unsigned TOT_W   = $clog2(ENTRIES + 1);

   state_type state_ff, state_in;

   logic [2:0]        cls_ff, cls_in;
   logic [30:0]       acct_ff, acct_in;
   logic [15:0]       ops_ff, ops_in;
   logic [2:0]        start_ff, start_in;
   logic [2:0]        probe_ff, probe_in;
   logic [2:0]        cur_ff, cur_in;
   logic [7:0]        sir_ff, sir_in;
   logic [CNT_W-1:0]  count_ff [0:NUM_CLASSES-1];
   logic [CNT_W-1:0]  count_in [0:NUM_CLASSES-1];
   logic [HEAD_W-1:0] head_ff [0:NUM_CLASSES-1];
   logic [HEAD_W-1:0] head_in [0:NUM_CLASSES-1];
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [7:0]        quota_ff [0:NUM_CLASSES-1];
   logic [7:0]        quota_in [0:NUM_CLASSES-1];
   logic [15:0]       tpo_ff, tpo_in;

   logic [1:0]        res_status_ff, res_status_in;
   logic [30:0]       res_acct_ff, res_acct_in;
   logic [15:0]       res_ops_ff, res_ops_in;
   logic [31:0]       res_time_ff, res_time_in;
   logic [2:0]        res_class_ff, res_class_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [30:0]       rsp_acct_ff, rsp_acct_in;
   logic [15:0]       rsp_ops_ff, rsp_ops_in;
   logic [31:0]       rsp_time_ff, rsp_time_in;
   logic [2:0]        rsp_class_ff, rsp_class_in;
   logic [6:0]        rsp_total_ff, rsp_total_in;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   entry_type         wr_entry, rd_entry;

   logic              cls_ok;
   logic [2:0]        enq_q, q_sel, cur_next;
   logic [CNT_W-1:0]  sel_count;
   logic [HEAD_W-1:0] sel_head, head_next, slot;
   logic [CNT_W:0]    slot_sum;
   logic              sel_empty, sel_full, advance, out_free;
   logic [ADDR_W-1:0] base;
   logic [31:0]       product;

   wrr5q_store #(
      .ENTRIES (ENTRIES)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_entry (wr_entry),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign cls_ok = (cls_ff >= 3'd1) && (cls_ff <= MAX_CLASS);
   assign enq_q  = cls_ok ? (cls_ff - 3'd1) : '0;
   assign q_sel  = (state_ff == S_EXEC) ? enq_q : cur_ff;

   // one read of the per-queue bookkeeping per cycle, at the selected queue
   assign sel_count = count_ff[q_sel];
   assign sel_head  = head_ff[q_sel];
   assign sel_empty = (sel_count == '0);
   assign sel_full  = (sel_count >= CNT_W'(QUEUE_DEPTH));

   assign cur_next  = (cur_ff == LAST_QUEUE) ? 3'd0 : cur_ff + 3'd1;
   assign head_next = (sel_head == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : sel_head + 1'b1;

   // tail slot: head plus count, wrapped once
   assign slot_sum = (CNT_W + 1)'(sel_head) + (CNT_W + 1)'(sel_count);
   assign slot     = (slot_sum >= (CNT_W + 1)'(QUEUE_DEPTH))
                   ? HEAD_W'(slot_sum - (CNT_W + 1)'(QUEUE_DEPTH))
                   : HEAD_W'(slot_sum);
   assign base     = ADDR_W'(q_sel) * ADDR_W'(QUEUE_DEPTH);

   assign product  = 32'(rd_entry.operations) * 32'(tpo_ff);

   // first probe honors the quota; later ones only skip empty queues
   assign advance  = (probe_ff == 3'd0)
                   ? ((sir_ff == quota_ff[cur_ff]) || sel_empty)
                   : (sel_empty && (probe_ff < PROBE_LIMIT));

   always_comb begin
      state_in      = state_ff;
      cls_in        = cls_ff;
      acct_in       = acct_ff;
      ops_in        = ops_ff;
      start_in      = start_ff;
      probe_in      = probe_ff;
      cur_in        = cur_ff;
      sir_in        = sir_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      total_in      = total_ff;
      quota_in      = quota_ff;
      tpo_in        = tpo_ff;
      res_status_in = res_status_ff;
      res_acct_in   = res_acct_ff;
      res_ops_in    = res_ops_ff;
      res_time_in   = res_time_ff;
      res_class_in  = res_class_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_acct_in   = rsp_acct_ff;
      rsp_ops_in    = rsp_ops_ff;
      rsp_time_in   = rsp_time_ff;
      rsp_class_in  = rsp_class_ff;
      rsp_total_in  = rsp_total_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_entry      = '{account: acct_ff, operations: ops_ff};
      rd_en         = 1'b0;
      rd_addr       = '0;

      if (csr_write_enable) begin
         unique case (csr_index)
            REG_QUOTA_CLASS1: quota_in[0] = csr_write_data[7:0];
            REG_QUOTA_CLASS2: quota_in[1] = csr_write_data[7:0];
            REG_QUOTA_CLASS3: quota_in[2] = csr_write_data[7:0];
            REG_QUOTA_CLASS4: quota_in[3] = csr_write_data[7:0];
            REG_QUOTA_CLASS5: quota_in[4] = csr_write_data[7:0];
            REG_TIME_PER_OP:  tpo_in      = csr_write_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cls_in        = req_class_number;
               acct_in       = req_account_number;
               ops_in        = req_operation_count;
               start_in      = cur_ff;
               probe_in      = 3'd0;
               res_status_in = STATUS_OK;
               res_acct_in   = '0;
               res_ops_in    = '0;
               res_time_in   = '0;
               res_class_in  = '0;
               state_in      = (req_command == CMD_SERVE) ? S_PROBE : S_EXEC;
            end
         end
         S_EXEC: begin
            if (cls_ok && !sel_full) begin
               wr_en           = 1'b1;
               wr_addr         = base + ADDR_W'(slot);
               count_in[q_sel] = sel_count + 1'b1;
               total_in        = total_ff + 1'b1;
            end else begin
               res_status_in = STATUS_FULL;
            end
            state_in = S_DONE;
         end
         S_PROBE: begin
            if (advance) begin
               cur_in   = cur_next;
               probe_in = probe_ff + 3'd1;
            end else begin
               if (start_ff != cur_ff) begin
                  sir_in = '0;
               end
               if (sel_empty) begin
                  res_status_in = STATUS_NO_CLIENT;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            rd_en           = 1'b1;
            rd_addr         = base + ADDR_W'(sel_head);
            head_in[q_sel]  = head_next;
            count_in[q_sel] = sel_count - 1'b1;
            total_in        = total_ff - 1'b1;
            sir_in          = sir_ff + 8'd1;
            res_class_in    = cur_ff;
            state_in        = S_MUL;
         end
         S_MUL: begin
            res_acct_in = rd_entry.account;
            res_ops_in  = rd_entry.operations;
            res_time_in = product;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_acct_in   = res_acct_ff;
               rsp_ops_in    = res_ops_ff;
               rsp_time_in   = res_time_ff;
               rsp_class_in  = res_class_ff;
               rsp_total_in  = 7'(total_ff);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         sir_ff       <= '0;
         total_ff     <= '0;
         tpo_ff       <= 16'd1;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            count_ff[i] <= '0;
            head_ff[i]  <= '0;
            quota_ff[i] <= 8'd1;
         end
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         sir_ff       <= sir_in;
         total_ff     <= total_in;
         tpo_ff       <= tpo_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         quota_ff     <= quota_in;
      end
   end

   always_ff @(posedge clock) begin
      cls_ff        <= cls_in;
      acct_ff       <= acct_in;
      ops_ff        <= ops_in;
      start_ff      <= start_in;
      probe_ff      <= probe_in;
      res_status_ff <= res_status_in;
      res_acct_ff   <= res_acct_in;
      res_ops_ff    <= res_ops_in;
      res_time_ff   <= res_time_in;
      res_class_ff  <= res_class_in;
      rsp_status_ff <= rsp_status_in;
      rsp_acct_ff   <= rsp_acct_in;
      rsp_ops_ff    <= rsp_ops_in;
      rsp_time_ff   <= rsp_time_in;
      rsp_class_ff  <= rsp_class_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_served_account    = rsp_acct_ff;
   assign rsp_served_operations = rsp_ops_ff;
   assign rsp_service_time      = rsp_time_ff;
   assign rsp_served_class      = rsp_class_ff;
   assign rsp_total_waiting     = rsp_total_ff;

`ifndef NO_ASSERTIONS
   a_total_matches_counts: assert property (@(posedge clock) disable iff (reset)
      total_ff == TOT_W'(count_ff[0]) + TOT_W'(count_ff[1]) + TOT_W'(count_ff[2])
                + TOT_W'(count_ff[3]) + TOT_W'(count_ff[4]))
      else $error("waiting total out of step with queue counts");

   a_beat_starts_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_PROBE || state_ff == S_EXEC))
      else $error("input beat did not start enqueue or probe");

   a_probe_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE) |-> (probe_ff <= PROBE_LIMIT && cur_ff <= LAST_QUEUE))
      else $error("probe sequencer ran past its limit");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH) |-> (count_ff[cur_ff] != '0))
      else $error("pop from an empty queue");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_weighted_round_robin_five_queues.sv =====
// testbench of the weighted round robin scheduler over five client queues
module tb_weighted_round_robin_five_queues;
   import wrr5q_pkg::*;

   localparam int unsigned DEPTH       = 16;
   localparam int unsigned HOLD_CYCLES = 80;

   typedef struct packed {
      logic [1:0]  status;
      logic [30:0] account;
      logic [15:0] operations;
      logic [31:0] cost;
      logic [2:0]  lane;
      logic [6:0]  waiting;
   } reply_type;

   // mirror of the five class queues and the round robin pointer
   class service_ledger;
      logic [30:0]  acct_store [NUM_CLASSES][DEPTH];
      logic [15:0]  ops_store [NUM_CLASSES][DEPTH];
      int unsigned  head [NUM_CLASSES];
      int unsigned  count [NUM_CLASSES];
      logic [2:0]   pointer;
      logic [7:0]   run_length;
      logic [7:0]   quota [NUM_CLASSES];
      logic [15:0]  op_cost;
      reply_type    due_replies[$];
      int unsigned  faults;
      int unsigned  answered;

      function new();
         foreach (head[i]) begin
            head[i] = 0;
            count[i] = 0;
            quota[i] = 8'd1;
         end
         pointer = 3'd0;
         run_length = 8'd0;
         op_cost = 16'd1;
         faults = 0;
         answered = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [15:0] data);
         case (idx)
            REG_QUOTA_CLASS1: quota[0] = data[7:0];
            REG_QUOTA_CLASS2: quota[1] = data[7:0];
            REG_QUOTA_CLASS3: quota[2] = data[7:0];
            REG_QUOTA_CLASS4: quota[3] = data[7:0];
            REG_QUOTA_CLASS5: quota[4] = data[7:0];
            REG_TIME_PER_OP:  op_cost = data;
            default: ;
         endcase
      endfunction

      function void admit_beat(logic cmd, logic [2:0] cls, logic [30:0] acct,
                               logic [15:0] ops);
         reply_type r;
         int unsigned q, slot, probes, total;
         logic [2:0]  start;
         r = '0;
         if (cmd == CMD_ENQUEUE) begin
            if (cls == 3'd0 || cls > MAX_CLASS) begin
               r.status = STATUS_FULL;
            end else begin
               q = cls - 1;
               if (count[q] >= DEPTH) begin
                  r.status = STATUS_FULL;
               end else begin
                  slot = (head[q] + count[q]) % DEPTH;
                  acct_store[q][slot] = acct;
                  ops_store[q][slot] = ops;
                  count[q]++;
               end
            end
         end else begin
            start = pointer;
            probes = 0;
            // leave the queue once its quota is used up or it runs dry
            do begin
               if (run_length == quota[pointer] || count[pointer] == 0)
                  pointer = (pointer == LAST_QUEUE) ? 3'd0 : pointer + 3'd1;
               probes++;
            end while (count[pointer] == 0 && probes < PROBE_LIMIT);
            if (pointer != start)
               run_length = 8'd0;
            if (count[pointer] == 0) begin
               r.status = STATUS_NO_CLIENT;
            end else begin
               r.status = STATUS_OK;
               r.account = acct_store[pointer][head[pointer]];
               r.operations = ops_store[pointer][head[pointer]];
               r.cost = 32'(r.operations) * 32'(op_cost);
               r.lane = pointer;
               head[pointer] = (head[pointer] + 1) % DEPTH;
               count[pointer]--;
               run_length = run_length + 8'd1;
            end
         end
         total = 0;
         foreach (count[i])
            total += count[i];
         r.waiting = total[6:0];
         due_replies.push_back(r);
      endfunction

      function void check_field(string label, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            faults++;
         end
      endfunction

      function void match_reply(reply_type got);
         reply_type want;
         answered++;
         if (due_replies.size() == 0) begin
            $display("%0t: reply beat with none outstanding, actual status %0d",
                     $time, got.status);
            faults++;
         end else begin
            want = due_replies.pop_front();
            check_field("status", 32'(want.status), 32'(got.status));
            check_field("served_account", 32'(want.account), 32'(got.account));
            check_field("served_operations", 32'(want.operations),
                        32'(got.operations));
            check_field("service_time", want.cost, got.cost);
            check_field("served_class", 32'(want.lane), 32'(got.lane));
            check_field("total_waiting", 32'(want.waiting), 32'(got.waiting));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = CMD_ENQUEUE;
   logic [2:0]  req_class_number = 3'd0;
   logic [30:0] req_account_number = '0;
   logic [15:0] req_operation_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [30:0] rsp_served_account;
   logic [15:0] rsp_served_operations;
   logic [31:0] rsp_service_time;
   logic [2:0]  rsp_served_class;
   logic [6:0]  rsp_total_waiting;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = REG_QUOTA_CLASS1;
   logic [15:0] csr_write_data = '0;

   service_ledger ledger = new();
   int unsigned   beats_sent = 0;
   bit            tx_jitter = 1'b0;
   bit            rx_jitter = 1'b0;
   bit            hold_ask = 1'b0;

   weighted_round_robin_five_queues #(.QUEUE_DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_class_number(req_class_number),
      .req_account_number(req_account_number),
      .req_operation_count(req_operation_count),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_served_account(rsp_served_account),
      .rsp_served_operations(rsp_served_operations),
      .rsp_service_time(rsp_service_time),
      .rsp_served_class(rsp_served_class),
      .rsp_total_waiting(rsp_total_waiting),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   // reply first, then the new request beat of the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable)
            ledger.set_reg(csr_index, csr_write_data);
         if (rsp_valid && !rsp_stall)
            ledger.match_reply('{rsp_status, rsp_served_account, rsp_served_operations,
                                 rsp_service_time, rsp_served_class, rsp_total_waiting});
         if (req_valid && !req_stall)
            ledger.admit_beat(req_command, req_class_number, req_account_number,
                              req_operation_count);
      end
   end

   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_ask) begin
            hold_ask = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rx_jitter && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic put_reg(input logic [2:0] idx, input logic [15:0] data);
      csr_index <= idx;
      csr_write_data <= data;
      csr_write_enable <= 1'b1;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [7:0] q1, input logic [7:0] q2,
                                input logic [7:0] q3, input logic [7:0] q4,
                                input logic [7:0] q5, input logic [15:0] cost);
      put_reg(REG_QUOTA_CLASS1, {8'd0, q1});
      put_reg(REG_QUOTA_CLASS2, {8'd0, q2});
      put_reg(REG_QUOTA_CLASS3, {8'd0, q3});
      put_reg(REG_QUOTA_CLASS4, {8'd0, q4});
      put_reg(REG_QUOTA_CLASS5, {8'd0, q5});
      put_reg(REG_TIME_PER_OP, cost);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send(input logic cmd, input logic [2:0] cls, input logic [30:0] acct,
                       input logic [15:0] ops);
      req_command <= cmd;
      req_class_number <= cls;
      req_account_number <= acct;
      req_operation_count <= ops;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      if (tx_jitter && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic serve_any();
      send(CMD_SERVE, 3'($urandom_range(0, 7)), 31'($urandom), 16'($urandom));
   endtask

   task automatic random_client(input int unsigned enq_pct, input logic [2:0] focus);
      logic        cmd;
      logic [2:0]  cls;
      logic [30:0] acct;
      logic [15:0] ops;
      int unsigned pick;
      cmd = ($urandom_range(1, 100) <= enq_pct) ? CMD_ENQUEUE : CMD_SERVE;
      pick = $urandom_range(0, 19);
      if (pick == 0)
         cls = 3'($urandom_range(0, 7));
      else if (focus != 3'd0 && pick < 12)
         cls = focus;
      else
         cls = 3'($urandom_range(1, 5));
      case ($urandom_range(0, 15))
         0: acct = '0;
         1: acct = '1;
         default: acct = 31'($urandom);
      endcase
      case ($urandom_range(0, 15))
         0: ops = '0;
         1: ops = '1;
         default: ops = 16'($urandom);
      endcase
      send(cmd, cls, acct, ops);
   endtask

   // bursts of 16 beats share an enqueue bias and sometimes a favored class
   task automatic run_random(input int unsigned n);
      int unsigned enq_pct;
      logic [2:0]  focus;
      enq_pct = 50;
      focus = 3'd0;
      for (int unsigned i = 0; i < n; i++) begin
         if (i % 16 == 0) begin
            enq_pct = $urandom_range(25, 95);
            focus = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(1, 5)) : 3'd0;
         end
         random_client(enq_pct, focus);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (ledger.answered < beats_sent)
         @(posedge clock);
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // zero quota on class 3 keeps the pointer there
      load_settings(8'd2, 8'd1, 8'd0, 8'd255, 8'd1, 16'hFFFF);
      tx_jitter = 1'b1;
      rx_jitter = 1'b1;
      serve_any();
      send(CMD_ENQUEUE, 3'd0, 31'($urandom), 16'($urandom));
      send(CMD_ENQUEUE, 3'd6, 31'($urandom), 16'($urandom));
      send(CMD_ENQUEUE, 3'd7, '1, '1);
      send(CMD_ENQUEUE, 3'd1, '1, '1);
      send(CMD_ENQUEUE, 3'd1, '0, '0);
      send(CMD_ENQUEUE, 3'd2, 31'($urandom), 16'($urandom));
      send(CMD_ENQUEUE, 3'd3, 31'($urandom), 16'($urandom));
      send(CMD_ENQUEUE, 3'd3, 31'($urandom), 16'($urandom));
      send(CMD_ENQUEUE, 3'd4, 31'($urandom), 16'($urandom));
      send(CMD_ENQUEUE, 3'd5, 31'($urandom), '1);
      repeat (10) serve_any();
      drain();

      load_settings(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                    8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                    8'($urandom_range(1, 4)), 16'($urandom));
      run_random(150);
      drain();

      load_settings(8'd0, 8'd255, 8'd0, 8'd255, 8'd1, 16'd0);
      run_random(100);
      drain();

      // receiver holds off long enough for the block to stall its input
      load_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 16'($urandom));
      hold_ask = 1'b1;
      run_random(150);
      drain();

      tx_jitter = 1'b0;
      rx_jitter = 1'b0;
      load_settings(8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 16'($urandom));
      run_random(150);
      drain();

      repeat (12) @(posedge clock);
      if (ledger.faults == 0 && ledger.due_replies.size() == 0)
         $display("weighted_round_robin_five_queues test passed");
      else
         $display("weighted_round_robin_five_queues test failed");
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("weighted_round_robin_five_queues test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/wrr5q_pkg.sv
src/wrr5q_store.sv
src/weighted_round_robin_five_queues.sv
dv/tb_weighted_round_robin_five_queues.sv
